// ===== hw/rtl/rgb_box_mean_filter_3x3_core_defines.svh =====
// Assertion macros shared by the RGB 3x3 mean filter RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef RGB_BOX_MEAN_FILTER_3X3_CORE_DEFINES_SVH
`define RGB_BOX_MEAN_FILTER_3X3_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define RBMF_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rbmf: implication check failed");
// Next-cycle implication
`define RBMF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rbmf: next-cycle check failed");
// Condition that must never be true
`define RBMF_ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("rbmf: forbidden condition seen");
`else
`define RBMF_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define RBMF_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`define RBMF_ASSERT_NEVER(lbl, ck, rn, expr)
`endif

`endif

// ===== hw/rtl/rbmf_pkg.sv =====
// Package for the RGB 3x3 mean filter: widths, pixel and tag types.
// No dependencies; imported by every module of the block except rbmf_ram.
package rbmf_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int CH_W              = 8;
    localparam int PIX_W             = 3 * CH_W;
    localparam int SUM_W             = 12;
    localparam int IMG_W_W           = 11;
    localparam int IMG_H_W           = 16;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 16;
    localparam int FIFO_DEPTH        = 8;

    // One RGB sample, red in the top byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // Per-step control carried down the pipeline
    typedef struct packed {
        logic emit;
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
        logic last;
    } tag_t;

    // One finished output pixel
    typedef struct packed {
        pixel_t px;
        logic   frame_end;
    } result_t;

endpackage

// ===== hw/rtl/rgb_box_mean_filter_3x3_core.sv =====
// Top level of the streaming RGB 3x3 box mean filter.
// Depends on rbmf_pkg, rbmf_ram, rbmf_ctrl, rbmf_window, rbmf_mean, rbmf_fifo.
//
// Pixels enter in raster order (kind 0), one per clock while in_ready is
// high; each output is the truncated per-channel mean of the in-image 3x3
// neighbors (divide by 4 at corners, 6 on edges, 9 inside). Outputs lag by
// one row plus one pixel, so after the last pixel of a frame send
// image_width + 1 flush items (kind 1); frame_end marks the last output and
// the next frame starts right after. The two line buffers are single-port-write,
// single-port-read RAMs touched once per item; the window shifts on each step
// and the sum registers load every clock. A result passes the s1, window and
// sum registers into an eight-entry output queue that absorbs backpressure,
// and in_ready drops only when that queue plus the results in flight fill it.
// Writing image_width (index 0) or image_height (index 1) restarts the frame;
// write them only while the block is idle. No clearing pass after reset.
module rgb_box_mean_filter_3x3_core
#(
    parameter int MAX_WIDTH = rbmf_pkg::MAX_WIDTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rbmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [rbmf_pkg::CH_W-1:0]        red_in,
    input  logic [rbmf_pkg::CH_W-1:0]        green_in,
    input  logic [rbmf_pkg::CH_W-1:0]        blue_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rbmf_pkg::CH_W-1:0]        red_out,
    output logic [rbmf_pkg::CH_W-1:0]        green_out,
    output logic [rbmf_pkg::CH_W-1:0]        blue_out,
    output logic                             frame_end
);

    import rbmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int OCC_W = $clog2(FIFO_DEPTH + 4);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic              accept;
    pixel_t            pixel;
    logic [CW-1:0]     rd_addr;
    logic              s1_valid;
    logic [CW-1:0]     s1_addr;
    pixel_t            s1_pixel;
    tag_t              s1_tag;
    logic [PIX_W-1:0]  older_rdata;
    logic [PIX_W-1:0]  recent_rdata;
    logic [PIX_W-1:0]  s1_pixel_vec;
    logic              s2_valid;
    tag_t              s2_tag;
    pixel_t [8:0]      window;
    logic              s3_valid;
    result_t           push_data;
    result_t           out_data;
    logic              pop;
    logic [CNT_W-1:0]  fifo_count;
    logic [OCC_W-1:0]  occupancy;

    // Reserve a queue slot for every result still in the pipeline
    assign occupancy = OCC_W'(s1_valid && s1_tag.emit)
                     + OCC_W'(s2_valid && s2_tag.emit)
                     + OCC_W'(s3_valid)
                     + OCC_W'(fifo_count);
    assign in_ready  = occupancy < OCC_W'(FIFO_DEPTH);
    assign accept    = in_valid && in_ready;

    assign pixel.red   = red_in;
    assign pixel.green = green_in;
    assign pixel.blue  = blue_in;

    rbmf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (kind),
        .pixel     (pixel),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1_addr   (s1_addr),
        .s1_pixel  (s1_pixel),
        .s1_tag    (s1_tag)
    );

    // Line buffers: the recent row moves into the older row on each step
    assign s1_pixel_vec = s1_pixel;

    rbmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_row
    (
        .clk   (clk),
        .we    (s1_valid),
        .waddr (s1_addr),
        .wdata (recent_rdata),
        .raddr (rd_addr),
        .rdata (older_rdata)
    );

    rbmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_recent_row
    (
        .clk   (clk),
        .we    (s1_valid),
        .waddr (s1_addr),
        .wdata (s1_pixel_vec),
        .raddr (rd_addr),
        .rdata (recent_rdata)
    );

    rbmf_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_tag   (s1_tag),
        .top      (pixel_t'(older_rdata)),
        .mid      (pixel_t'(recent_rdata)),
        .s1_pixel (s1_pixel),
        .s2_valid (s2_valid),
        .s2_tag   (s2_tag),
        .window   (window)
    );

    rbmf_mean u_mean
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_tag    (s2_tag),
        .window    (window),
        .s3_valid  (s3_valid),
        .push_data (push_data)
    );

    assign pop = out_valid && out_ready;

    rbmf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid),
        .push_data (push_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign red_out   = out_data.px.red;
    assign green_out = out_data.px.green;
    assign blue_out  = out_data.px.blue;
    assign frame_end = out_data.frame_end;

endmodule

// ===== hw/rtl/rbmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module rbmf_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rbmf_ctrl.sv =====
// Input control of the 3x3 mean filter: config registers, position counters,
// flush handling and neighbor flags. Depends on rbmf_pkg and the defines header.
`include "rgb_box_mean_filter_3x3_core_defines.svh"

module rbmf_ctrl
#(
    parameter int MAX_WIDTH = rbmf_pkg::MAX_WIDTH_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rbmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbmf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  logic                               kind,
    input  rbmf_pkg::pixel_t                   pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
    output logic                               s1_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]       s1_addr,
    output rbmf_pkg::pixel_t                   s1_pixel,
    output rbmf_pkg::tag_t                     s1_tag
);

    import rbmf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > IMG_W_W) ? WW : IMG_W_W;
    localparam int RW1 = IMG_H_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    logic [IMG_W_W-1:0] width_reg,   width_next;
    logic [IMG_H_W-1:0] height_reg,  height_next;
    logic [CW-1:0]      in_col_reg,  in_col_next;
    logic [IMG_H_W-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0]      out_col_reg, out_col_next;
    logic [IMG_H_W-1:0] out_row_reg, out_row_next;

    logic               s1_valid_reg;
    logic [CW-1:0]      s1_addr_reg;
    pixel_t             s1_pixel_reg;
    tag_t               s1_tag_reg;

    logic [EW-1:0]      width_ext;
    logic [WW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic               draining;
    logic               step;
    logic               emit;
    logic [WW-1:0]      in_col_inc;
    logic [WW-1:0]      out_col_inc;
    logic [RW1-1:0]     out_row_inc;
    logic [WW-1:0]      in_col_ext;
    logic               flush_drop;
    logic               last_step;
    tag_t               tag;

    // Effective frame size: width saturated to 2..MAX_WIDTH, height at least 2
    always_comb
    begin
        width_ext = EW'(width_reg);
        if (width_ext < EW'(2))
        begin
            w_eff = WW'(2);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_ext);
        end
        h_eff = (height_reg < IMG_H_W'(2)) ? IMG_H_W'(2) : height_reg;
    end

    // Classify the transfer and build the neighbor flags of the next output
    always_comb
    begin
        draining    = in_row_reg >= h_eff;
        step        = accept && (!kind || draining);
        flush_drop  = accept && kind && !draining;
        emit        = (in_row_reg >= IMG_H_W'(2))
                   || ((in_row_reg == IMG_H_W'(1)) && (in_col_reg != '0));
        in_col_ext  = WW'(in_col_reg);
        in_col_inc  = in_col_ext + WW'(1);
        out_col_inc = WW'(out_col_reg) + WW'(1);
        out_row_inc = RW1'(out_row_reg) + RW1'(1);

        tag.emit      = emit;
        tag.row_top   = out_row_reg != '0;
        tag.row_bot   = out_row_inc < RW1'(h_eff);
        tag.col_left  = out_col_reg != '0;
        tag.col_right = out_col_inc < w_eff;
        tag.last      = !tag.row_bot && !tag.col_right;
        last_step     = step && emit && tag.last;
    end

    // Next values of config registers and position counters
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[IMG_H_W-1:0];
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (step)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_col_next = '0;
                if (!draining)
                begin
                    in_row_next = in_row_reg + IMG_H_W'(1);
                end
            end
            else
            begin
                in_col_next = CW'(in_col_inc);
            end
            if (emit)
            begin
                if (tag.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_inc >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + IMG_H_W'(1);
                end
                else
                begin
                    out_col_next = CW'(out_col_inc);
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= IMG_W_W'(1024);
            height_reg   <= IMG_H_W'(2);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            s1_valid_reg <= step;
        end
    end

    // Stage payload: drained steps push black into the line buffers
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= in_col_reg;
        s1_pixel_reg <= draining ? pixel_t'('0) : pixel;
        s1_tag_reg   <= tag;
    end

    assign rd_addr  = in_col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_pixel = s1_pixel_reg;
    assign s1_tag   = s1_tag_reg;

    `RBMF_ASSERT_NEXT(a_flush_ignored, clk, rst_n, flush_drop, !s1_valid_reg)
    `RBMF_ASSERT_NEVER(a_col_in_range, clk, rst_n, in_col_ext >= w_eff)
    `RBMF_ASSERT_NEXT(a_last_restarts, clk, rst_n, last_step, (in_col_reg == '0) && (out_row_reg == '0))

endmodule

// ===== hw/rtl/rbmf_window.sv =====
// 3x3 window of the mean filter: shifts in one column per step from the
// two line buffers and the new pixel. Depends on rbmf_pkg.
module rbmf_window
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s1_valid,
    input  rbmf_pkg::tag_t        s1_tag,
    input  rbmf_pkg::pixel_t      top,
    input  rbmf_pkg::pixel_t      mid,
    input  rbmf_pkg::pixel_t      s1_pixel,
    output logic                  s2_valid,
    output rbmf_pkg::tag_t        s2_tag,
    output rbmf_pkg::pixel_t [8:0] window
);

    import rbmf_pkg::*;

    // Index is column * 3 + row; column 0 is the oldest (left) column
    pixel_t [8:0] win_reg;
    logic         s2_valid_reg;
    tag_t         s2_tag_reg;

    // Advance the window by one column on every step
    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= win_reg[k + 3];
            end
            win_reg[6] <= top;
            win_reg[7] <= mid;
            win_reg[8] <= s1_pixel;
        end
        s2_tag_reg <= s1_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_tag   = s2_tag_reg;
    assign window   = win_reg;

endmodule

// ===== hw/rtl/rbmf_mean.sv =====
// Neighborhood sum and divide by 4, 6 or 9 for the 3x3 mean filter.
// Depends on rbmf_pkg; divides by 6 and 9 use reciprocal multiplies.
module rbmf_mean
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s2_valid,
    input  rbmf_pkg::tag_t         s2_tag,
    input  rbmf_pkg::pixel_t [8:0] window,
    output logic                   s3_valid,
    output rbmf_pkg::result_t      push_data
);

    import rbmf_pkg::*;

    typedef enum logic [1:0] {DIV_4, DIV_6, DIV_9} div_t;

    // floor(x / 6) is exact for x < 8192 and floor(x / 9) for x < 3276 with
    // these; a nine-pixel sum never exceeds 2295
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_6     = 2731;
    localparam int RECIP_9     = 1821;
    localparam int PROD_W      = SUM_W + 12;

    logic [SUM_W-1:0] col_sum [3][3];
    logic [SUM_W-1:0] total   [3];
    div_t             div_sel;

    logic             s3_valid_reg;
    logic [SUM_W-1:0] s3_sum_reg [3];
    div_t             s3_div_reg;
    logic             s3_last_reg;
    logic [CH_W-1:0]  mean [3];

    function automatic logic [CH_W-1:0] div_mean(input logic [SUM_W-1:0] s,
                                                 input div_t d);
        logic [PROD_W-1:0] prod;
        logic [CH_W-1:0]   q;
        begin
            prod = '0;
            unique case (d)
                DIV_4:
                begin
                    q = s[2 +: CH_W];
                end
                DIV_6:
                begin
                    prod = PROD_W'(s) * PROD_W'(RECIP_6);
                    q    = prod[RECIP_SHIFT +: CH_W];
                end
                DIV_9:
                begin
                    prod = PROD_W'(s) * PROD_W'(RECIP_9);
                    q    = prod[RECIP_SHIFT +: CH_W];
                end
                default:
                begin
                    q = '0;
                end
            endcase
            return q;
        end
    endfunction

    // Column sums over in-image rows, then total over in-image columns
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                col_sum[c][ch] =
                    (s2_tag.row_top ? SUM_W'(window[c*3][(2-ch)*CH_W +: CH_W]) : '0)
                  + SUM_W'(window[c*3+1][(2-ch)*CH_W +: CH_W])
                  + (s2_tag.row_bot ? SUM_W'(window[c*3+2][(2-ch)*CH_W +: CH_W]) : '0);
            end
            total[ch] = (s2_tag.col_left  ? col_sum[0][ch] : '0)
                      + col_sum[1][ch]
                      + (s2_tag.col_right ? col_sum[2][ch] : '0);
        end
        // Corner: 4 neighbors, full interior: 9, otherwise an edge: 6
        if (s2_tag.row_top && s2_tag.row_bot && s2_tag.col_left && s2_tag.col_right)
        begin
            div_sel = DIV_9;
        end
        else if ((s2_tag.row_top ^ s2_tag.row_bot) && (s2_tag.col_left ^ s2_tag.col_right))
        begin
            div_sel = DIV_4;
        end
        else
        begin
            div_sel = DIV_6;
        end
    end

    // Register sums every clock; only steps that produce an output set s3_valid
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            s3_sum_reg[ch] <= total[ch];
        end
        s3_div_reg  <= div_sel;
        s3_last_reg <= s2_tag.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid && s2_tag.emit;
        end
    end

    // Divide and pack the result
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            mean[ch] = div_mean(s3_sum_reg[ch], s3_div_reg);
        end
    end

    assign s3_valid               = s3_valid_reg;
    assign push_data.px.red       = mean[0];
    assign push_data.px.green     = mean[1];
    assign push_data.px.blue      = mean[2];
    assign push_data.frame_end    = s3_last_reg;

endmodule

// ===== hw/rtl/rbmf_fifo.sv =====
// Small output queue of the mean filter; decouples the pipeline from
// output backpressure. Depends on rbmf_pkg and the defines header.
`include "rgb_box_mean_filter_3x3_core_defines.svh"

module rbmf_fifo
#(
    parameter int DEPTH = rbmf_pkg::FIFO_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  rbmf_pkg::result_t            push_data,
    input  logic                         pop,
    output logic                         out_valid,
    output rbmf_pkg::result_t            out_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    import rbmf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    // Advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    `RBMF_ASSERT_IMPLY(a_push_has_room, clk, rst_n, push, count_reg < CNT_W'(DEPTH))

endmodule
